// ----- design/bh_qvalue_engine_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the BH q-value engine
// Concurrent checks that are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BH_QVALUE_ENGINE_MACROS_SVH
`define BH_QVALUE_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define BHQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bhq check failed");
// Next-cycle implication.
`define BHQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bhq check failed");
`else
`define BHQ_ASSERT_NOW(label, ante, cons)
`define BHQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/bhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bhq_pkg
// Fixed widths and codes shared by the BH q-value engine files.
// ----------------------------------------------------------------------------
`default_nettype none
package bhq_pkg;
  // Width of the test count register.
  localparam int TC_W = 11;
  localparam int STATUS_W = 2;

  // Transaction operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Read status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
endpackage
`default_nettype wire

// ----- design/bhq_in_if.sv -----
// ----------------------------------------------------------------------------
// bhq_in_if
// Input channel: load and read transactions with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface bhq_in_if #(
  parameter int IW = 10,
  parameter int QW = 33
);
  logic          valid;
  logic          ready;
  logic          operation;
  logic [QW-1:0] p_value;
  logic          last;
  logic [IW-1:0] read_index;

  modport source (output valid, operation, p_value, last, read_index, input ready);
  modport sink (input valid, operation, p_value, last, read_index, output ready);
endinterface
`default_nettype wire

// ----- design/bhq_out_if.sv -----
// ----------------------------------------------------------------------------
// bhq_out_if
// Result channel: q-value read responses with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface bhq_out_if #(
  parameter int IW = 10,
  parameter int QW = 33
);
  logic                          valid;
  logic                          ready;
  logic [QW-1:0]                 q_value;
  logic [IW-1:0]                 result_index;
  logic [bhq_pkg::STATUS_W-1:0]  status;

  modport source (output valid, q_value, result_index, status, input ready);
  modport sink (input valid, q_value, result_index, status, output ready);
endinterface
`default_nettype wire

// ----- design/bhq_divider.sv -----
// ----------------------------------------------------------------------------
// bhq_divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bh_qvalue_engine_macros.svh"
module bhq_divider #(
  parameter int DW = 44,
  parameter int VW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);
  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VW-1:0]    rem_r;
  logic [VW-1:0]    dsr_r;
  logic [DW-1:0]    quo_r;
  logic [VW:0]      trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_r, quo_r[DW-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and the shared dividend/quotient register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= fits ? VW'(trial - {1'b0, dsr_r}) : trial[VW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `BHQ_ASSERT_NEXT(a_div_done_after_busy, done_r, !busy_r)
  `BHQ_ASSERT_NOW(a_div_no_restart, busy_r, !start)
  `BHQ_ASSERT_NOW(a_div_rem_below, busy_r, rem_r < dsr_r)
endmodule
`default_nettype wire

// ----- design/bh_qvalue_engine.sv -----
// Loads and reads: one transaction per cycle while idle and the result channel
// is not stalled; a read answers on the next cycle. After a load marked last
// the block is not ready while it ranks the batch (one p-value memory read per
// cycle), then runs the step-up pass through the bit-serial divider. Reset clears
// the control state, batch count, ready flag and output valid and sets tc_r to 1.
// ----------------------------------------------------------------------------
// bh_qvalue_engine
// Benjamini-Hochberg q-value computation over memories for p-values,
// sorted positions and q-values.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bh_qvalue_engine_macros.svh"
module bh_qvalue_engine #(
  parameter int MAX_TESTS     = 1024,
  parameter int FRACTION_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [bhq_pkg::TC_W-1:0] cfg_wdata,
  bhq_in_if.sink                        in_ch,
  bhq_out_if.source                     out_ch
);
  localparam int IW = $clog2(MAX_TESTS);
  localparam int CW = $clog2(MAX_TESTS + 1);
  localparam int QW = FRACTION_BITS + 1;
  localparam int PW = QW + bhq_pkg::TC_W;
  localparam logic [QW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RK_LD  = 4'd1;
  localparam logic [3:0] S_RK_PI  = 4'd2;
  localparam logic [3:0] S_RK_SW  = 4'd3;
  localparam logic [3:0] S_RK_WR  = 4'd4;
  localparam logic [3:0] S_SU_POS = 4'd5;
  localparam logic [3:0] S_SU_PV  = 4'd6;
  localparam logic [3:0] S_SU_MUL = 4'd7;
  localparam logic [3:0] S_SU_GO  = 4'd8;
  localparam logic [3:0] S_SU_DIV = 4'd9;
  localparam logic [3:0] S_SU_WR  = 4'd10;

  // Memories.
  logic [QW-1:0] pv_mem  [MAX_TESTS];
  logic [IW-1:0] pos_mem [MAX_TESTS];
  logic [QW-1:0] q_mem   [MAX_TESTS];

  logic [3:0]                 state_r;
  logic [3:0]                 state_nxt;
  logic [bhq_pkg::TC_W-1:0]   tc_r;
  logic [CW-1:0]              count_r;
  logic                       ready_r;
  logic [IW-1:0]              last_idx_r;
  logic [IW-1:0]              i_r;
  logic [IW-1:0]              j_r;
  logic [IW-1:0]              j_d_r;
  logic                       cmp_v_r;
  logic [IW-1:0]              rank_r;
  logic [IW-1:0]              rank_sum;
  logic                       hit;
  logic [QW-1:0]              pi_r;
  logic [CW-1:0]              k_r;
  logic [IW-1:0]              idx_r;
  logic [QW-1:0]              run_r;
  logic [PW-1:0]              prod_r;
  logic [PW-1:0]              quot;
  logic                       div_done;
  logic [QW-1:0]              t_sat;
  logic [QW-1:0]              run_min;
  logic [IW-1:0]              pv_raddr;
  logic [QW-1:0]              pv_rd_r;
  logic [IW-1:0]              pos_rd_r;
  logic [QW-1:0]              q_rd_r;
  logic                       out_valid_r;
  logic [IW-1:0]              out_idx_r;
  logic [bhq_pkg::STATUS_W-1:0] out_st_r;
  logic                       acc;
  logic                       acc_load;
  logic                       acc_read;
  logic [CW-1:0]              base_cnt;
  logic [CW-1:0]              new_cnt;
  logic [QW-1:0]              p_sat;
  logic                       pv_we;

  // Handshake.
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;
  assign acc_load    = acc && (in_ch.operation == bhq_pkg::OP_LOAD);
  assign acc_read    = acc && (in_ch.operation == bhq_pkg::OP_READ);

  // Load bookkeeping: a load after a finished batch opens a new one.
  assign p_sat    = (in_ch.p_value > ONE) ? ONE : in_ch.p_value;
  assign base_cnt = ready_r ? '0 : count_r;
  assign pv_we    = acc_load && (base_cnt < CW'(MAX_TESTS));
  assign new_cnt  = pv_we ? CW'(base_cnt + 1'b1) : base_cnt;

  // Ranking compare: smaller value, or equal value at an earlier position.
  assign hit      = (pv_rd_r < pi_r) || ((pv_rd_r == pi_r) && (j_d_r < i_r));
  assign rank_sum = cmp_v_r ? IW'(rank_r + hit) : rank_r;

  // Step-up: saturate the quotient and fold it into the running minimum.
  assign t_sat   = (quot > PW'(ONE)) ? ONE : quot[QW-1:0];
  assign run_min = (t_sat < run_r) ? t_sat : run_r;

  // P-value memory read address.
  always_comb begin
    case (state_r)
      S_RK_LD: pv_raddr = i_r;
      S_SU_PV: pv_raddr = pos_rd_r;
      default: pv_raddr = j_r;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (acc_load && in_ch.last && (new_cnt != '0)) state_nxt = S_RK_LD;
      S_RK_LD:  state_nxt = S_RK_PI;
      S_RK_PI:  state_nxt = S_RK_SW;
      S_RK_SW:  if (j_r == last_idx_r) state_nxt = S_RK_WR;
      S_RK_WR:  state_nxt = (i_r == last_idx_r) ? S_SU_POS : S_RK_LD;
      S_SU_POS: state_nxt = S_SU_PV;
      S_SU_PV:  state_nxt = S_SU_MUL;
      S_SU_MUL: state_nxt = S_SU_GO;
      S_SU_GO:  state_nxt = S_SU_DIV;
      S_SU_DIV: if (div_done) state_nxt = S_SU_WR;
      S_SU_WR:  state_nxt = (k_r == CW'(1)) ? S_IDLE : S_SU_POS;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tc_r        <= bhq_pkg::TC_W'(1);
      count_r     <= '0;
      ready_r     <= 1'b0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) tc_r <= cfg_wdata;
      if (acc_load) begin
        count_r <= new_cnt;
        ready_r <= in_ch.last && (new_cnt == '0);
      end
      if (state_r == S_SU_WR && k_r == CW'(1)) ready_r <= 1'b1;
      cmp_v_r <= (state_r == S_RK_SW);
      if (acc_read) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (acc_load && in_ch.last) begin
      last_idx_r <= IW'(new_cnt - 1'b1);
      i_r        <= '0;
      k_r        <= new_cnt;
      run_r      <= ONE;
    end
    if (state_r == S_RK_PI) begin
      pi_r   <= pv_rd_r;
      j_r    <= '0;
      rank_r <= '0;
    end
    if (state_r == S_RK_SW) begin
      j_d_r <= j_r;
      j_r   <= IW'(j_r + 1'b1);
    end
    if (cmp_v_r) rank_r <= rank_sum;
    if (state_r == S_RK_WR) i_r <= IW'(i_r + 1'b1);
    if (state_r == S_SU_PV) idx_r <= pos_rd_r;
    if (state_r == S_SU_MUL) prod_r <= pv_rd_r * tc_r;
    if (state_r == S_SU_WR) begin
      run_r <= run_min;
      k_r   <= k_r - 1'b1;
    end
  end

  // Memory ports, each read registered.
  always_ff @(posedge clk) begin
    if (pv_we) pv_mem[base_cnt[IW-1:0]] <= p_sat;
    pv_rd_r <= pv_mem[pv_raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RK_WR) pos_mem[rank_sum] <= i_r;
    pos_rd_r <= pos_mem[IW'(k_r - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SU_WR) q_mem[idx_r] <= run_min;
    if (acc_read) q_rd_r <= q_mem[in_ch.read_index];
  end

  // Read response register.
  always_ff @(posedge clk) begin
    if (acc_read) begin
      out_idx_r <= in_ch.read_index;
      if (!ready_r) out_st_r <= bhq_pkg::ST_NOT_READY;
      else if (CW'(in_ch.read_index) >= count_r) out_st_r <= bhq_pkg::ST_RANGE;
      else out_st_r <= bhq_pkg::ST_OK;
    end
  end

  bhq_divider #(.DW(PW), .VW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_SU_GO),
    .dividend (prod_r),
    .divisor  (k_r),
    .done     (div_done),
    .quotient (quot)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.q_value      = (out_st_r == bhq_pkg::ST_OK) ? q_rd_r : '0;
  assign out_ch.result_index = out_idx_r;
  assign out_ch.status       = out_st_r;

  `BHQ_ASSERT_NOW(a_busy_not_ready, state_r != S_IDLE, !ready_r)
  `BHQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(MAX_TESTS))
  `BHQ_ASSERT_NOW(a_q_bound, out_valid_r && out_st_r == bhq_pkg::ST_OK, q_rd_r <= ONE)
  `BHQ_ASSERT_NEXT(a_step_ends_ready, state_r == S_SU_WR && k_r == CW'(1), ready_r)
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Benjamini-Hochberg q-value engine. Batches of
// p-values are loaded and the q-values read back, with random gaps on both
// channels and one long receiver stall. A model in the bench ranks each batch,
// applies the step-up minimum and checks every read response in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [32:0] Q_ONE = 33'h1_0000_0000;
  localparam int DEPTH = 1024;

  typedef struct {
    logic        op;
    logic [32:0] p;
    logic        last;
    logic [9:0]  idx;
  } txn_t;

  typedef struct {
    logic [32:0]                  q;
    logic [9:0]                   idx;
    logic [bhq_pkg::STATUS_W-1:0] st;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [bhq_pkg::TC_W-1:0] cfg_wdata = '0;

  bhq_in_if #(.IW(10), .QW(33)) in_bus ();
  bhq_out_if #(.IW(10), .QW(33)) out_bus ();

  bh_qvalue_engine DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_bus), .out_ch(out_bus)
  );

  always #6 clk = ~clk;

  // Model state of the engine.
  logic [32:0] pval_mem [DEPTH];
  logic [32:0] qval_mem [DEPTH];
  int          rank_pos [DEPTH];
  int          batch_len;
  bit          batch_done;
  logic [bhq_pkg::TC_W-1:0] test_count;

  txn_t    pending_txns [$];
  answer_t expected_answers [$];
  bit      failed;
  bit      hold_request;

  // Ranks the batch stably by p-value and forms the step-up q-values.
  task automatic rank_and_adjust();
    int k, j, key;
    logic [63:0] t;
    logic [32:0] running;
    running = Q_ONE;
    for (k = 0; k < batch_len; k++) rank_pos[k] = k;
    for (k = 1; k < batch_len; k++) begin
      key = rank_pos[k];
      j = k;
      while (j > 0 && pval_mem[rank_pos[j-1]] > pval_mem[key]) begin
        rank_pos[j] = rank_pos[j-1];
        j--;
      end
      rank_pos[j] = key;
    end
    for (k = batch_len; k >= 1; k--) begin
      t = (64'(pval_mem[rank_pos[k-1]]) * 64'(test_count)) / 64'(k);
      if (t > 64'(Q_ONE)) t = 64'(Q_ONE);
      if (t[32:0] < running) running = t[32:0];
      qval_mem[rank_pos[k-1]] = running;
    end
    batch_done = 1'b1;
  endtask

  // Applies one accepted transaction to the model.
  task automatic predict_qvalue(input txn_t tr);
    answer_t a;
    logic [32:0] p;
    if (tr.op == bhq_pkg::OP_LOAD) begin
      p = (tr.p > Q_ONE) ? Q_ONE : tr.p;
      if (batch_done) begin
        batch_done = 1'b0;
        batch_len = 0;
      end
      if (batch_len < DEPTH) begin
        pval_mem[batch_len] = p;
        batch_len++;
      end
      if (tr.last) rank_and_adjust();
    end else begin
      a.idx = tr.idx;
      a.q = '0;
      if (!batch_done) a.st = bhq_pkg::ST_NOT_READY;
      else if (int'(tr.idx) >= batch_len) a.st = bhq_pkg::ST_RANGE;
      else begin
        a.st = bhq_pkg::ST_OK;
        a.q = qval_mem[tr.idx];
      end
      expected_answers = {expected_answers, a};
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Driver: offers queued transactions with random gaps.
  txn_t cur_txn;
  int   send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) predict_qvalue(cur_txn);
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0 || pending_txns.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_bus.valid <= 1'b0;
        end else begin
          cur_txn = pending_txns.pop_front();
          in_bus.operation <= cur_txn.op;
          in_bus.p_value <= cur_txn.p;
          in_bus.last <= cur_txn.last;
          in_bus.read_index <= cur_txn.idx;
          in_bus.valid <= 1'b1;
          send_gap = pick_gap();
        end
      end
    end
  end

  // Monitor: random back-pressure and in-order comparison of responses.
  int hold_cnt = 0;
  answer_t want;
  always @(posedge clk) begin
    if (out_bus.valid && out_bus.ready && rst_n) begin
      if (expected_answers.size() == 0) begin
        failed = 1'b1;
        $display("%0t: unexpected response idx %0d q %h st %0d", $time,
                 out_bus.result_index, out_bus.q_value, out_bus.status);
      end else begin
        want = expected_answers.pop_front();
        if (out_bus.q_value !== want.q || out_bus.result_index !== want.idx ||
            out_bus.status !== want.st) begin
          failed = 1'b1;
          $display("%0t: mismatch expected idx %0d q %h st %0d, got idx %0d q %h st %0d",
                   $time, want.idx, want.q, want.st, out_bus.result_index,
                   out_bus.q_value, out_bus.status);
        end
      end
    end
    if (hold_request) begin
      hold_request = 1'b0;
      hold_cnt = 1500;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_bus.ready <= 1'b0;
    end else if (pick_gap() > 0) begin
      hold_cnt = pick_gap();
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  task automatic queue_load(input logic [32:0] p, input logic lst);
    txn_t t;
    t.op = bhq_pkg::OP_LOAD;
    t.p = p;
    t.last = lst;
    t.idx = 10'($urandom());
    pending_txns = {pending_txns, t};
  endtask

  task automatic queue_read(input logic [9:0] idx);
    txn_t t;
    t.op = bhq_pkg::OP_READ;
    t.p = {1'($urandom()), 32'($urandom())};
    t.last = 1'($urandom());
    t.idx = idx;
    pending_txns = {pending_txns, t};
  endtask

  task automatic wait_drained();
    while (pending_txns.size() != 0 || in_bus.valid || expected_answers.size() != 0)
      @(posedge clk);
  endtask

  // A read only returns once any ranking pass has finished, so the block is
  // idle when its answer has arrived.
  task automatic write_test_count(input logic [bhq_pkg::TC_W-1:0] v);
    queue_read(10'd0);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    test_count = v;
  endtask

  function automatic logic [32:0] random_pvalue();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 14) return Q_ONE;
    if (r < 20) return {1'b1, 32'($urandom())};
    if (r < 50) return 33'($urandom_range(1 << 20));
    return {1'b0, 32'($urandom())};
  endfunction

  // Random batch with ties, reads before and after completion.
  task automatic queue_batch(input int n, input int reads);
    logic [32:0] vals [$];
    logic [32:0] p;
    int k;
    for (k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(3) == 0) p = vals[$urandom_range(k - 1)];
      else p = random_pvalue();
      vals = {vals, p};
      queue_load(p, k == n - 1);
      if ($urandom_range(9) == 0) queue_read(10'($urandom()));
    end
    for (k = 0; k < reads; k++) begin
      if ($urandom_range(7) == 0) queue_read(10'($urandom()));
      else queue_read(10'($urandom_range(n - 1)));
    end
  endtask

  int sent;
  int n;
  initial begin
    in_bus.valid = 1'b0;
    in_bus.operation = bhq_pkg::OP_LOAD;
    in_bus.p_value = '0;
    in_bus.last = 1'b0;
    in_bus.read_index = '0;
    out_bus.ready = 1'b0;
    failed = 1'b0;
    hold_request = 1'b0;
    batch_len = 0;
    batch_done = 1'b0;
    test_count = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reads before any batch, saturation, ties, extreme values.
    queue_read(10'd0);
    queue_read(10'd1023);
    queue_load(Q_ONE + 33'd5, 1'b0);
    queue_load('0, 1'b0);
    queue_read(10'd1);
    queue_load(Q_ONE, 1'b0);
    queue_load(33'h0_8000_0000, 1'b0);
    queue_load(33'h0_8000_0000, 1'b0);
    queue_load(33'h1_FFFF_FFFF, 1'b1);
    for (int i = 0; i < 7; i++) queue_read(10'(i));
    queue_read(10'd1023);
    write_test_count(11'd0);
    queue_batch(3, 4);
    write_test_count(11'd2047);
    queue_batch(5, 6);

    // Receiver stalls for a long stretch while reads keep coming.
    wait_drained();
    hold_request = 1'b1;
    queue_batch(8, 40);
    write_test_count(11'd1024);

    // Random batches, mostly small, now and then a new test count.
    sent = 0;
    while (sent < 500) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
      queue_batch(n, n + $urandom_range(4));
      sent += 2 * n + 2;
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(3))
          0: write_test_count(11'd1);
          1: write_test_count(11'd1024);
          default: write_test_count(11'($urandom_range(1024, 1)));
        endcase
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (!failed) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: far above the longest run, large batches and stalls included.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+design
design/bhq_pkg.sv
design/bhq_in_if.sv
design/bhq_out_if.sv
design/bhq_divider.sv
design/bh_qvalue_engine.sv
verif/testbench.sv
